[rtl/psvs_pkg.sv]
// ----------------------------------------------------------------------------
// psvs_pkg
// Shared types, codes, constants and table builders of the sine voice synth.
// ----------------------------------------------------------------------------
package psvs_pkg;

   localparam int VOICES_DEF    = 10;
   localparam int SINE_BITS_DEF = 10;

   localparam int ACTION_W   = 2;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int SAMPLE_W   = 22;
   localparam int LEVEL_W    = 24;
   localparam int PHASE_W    = 32;
   localparam int COUNT_W    = 16;
   localparam int LPV_W      = 18;
   localparam int SINE_W     = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int NOTE_NUM   = 128;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_NOTE_ON  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LPV     = 2'd3;

   // register reset values
   localparam logic [COUNT_W-1:0] ATTACK_RST  = 16'd441;
   localparam logic [COUNT_W-1:0] RELEASE_RST = 16'd2205;
   localparam logic [LEVEL_W-1:0] DECAY_RST   = 24'd16777048;
   localparam logic [LPV_W-1:0]   LPV_RST     = 18'd33554;

   localparam logic signed [SAMPLE_W-1:0] MIX_MAX = 22'sh1FFFFF;
   localparam logic signed [SAMPLE_W-1:0] MIX_MIN = 22'sh200000;

   typedef enum logic [1:0] {
      STG_ATTACK  = 2'd0,
      STG_SUSTAIN = 2'd1,
      STG_RELEASE = 2'd2,
      STG_FREED   = 2'd3
   } stage_type;

   typedef struct packed {
      logic                active;
      stage_type           stage;
      logic [NOTE_W-1:0]   note;
      logic [PHASE_W-1:0]  phase;
      logic [LEVEL_W-1:0]  level;
      logic [LEVEL_W-1:0]  target;
      logic [COUNT_W-1:0]  attack_left;
      logic [COUNT_W-1:0]  release_left;
   } voice_type;

   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned SEMI_FRAC   = 64'd255392046;
   localparam longint unsigned REF_INC_Q12 = 64'd2742546010;

   // Quarter-wave sine point k of 2^qb, Taylor series in Q30, result Q17.
   function automatic logic [SINE_W-1:0] sine_quarter(input int unsigned k,
                                                     input int unsigned qb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned v;
      x  = (longint'(k) * HALF_PI_Q30) >> qb;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      v  = (s + 64'd4096) >> 13;
      if (v > 64'd131072) begin
         v = 64'd131072;
      end
      return v[SINE_W-1:0];
   endfunction

   // Phase increment per tick for a MIDI note.
   function automatic logic [PHASE_W-1:0] pitch_inc(input int unsigned note);
      int unsigned     n;
      int unsigned     oct;
      int unsigned     semi;
      longint unsigned v;
      n    = (note & 127) + 3;
      oct  = n / 12;
      semi = n % 12;
      v    = REF_INC_Q12;
      for (int i = 0; i < 11; i++) begin
         if (i < semi) begin
            v = v + ((v * SEMI_FRAC + 64'd2147483648) >> 32);
         end
      end
      v = ((v << oct) + 64'd2048) >> 12;
      return v[PHASE_W-1:0];
   endfunction

endpackage

[rtl/polyphonic_sine_voice_synth.sv]
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_synth
// Multi-voice sine synthesizer with attack, sustain decay and release.
// ----------------------------------------------------------------------------
// Each request transaction is a note-on, a note-off or a sample tick; only a
// tick yields a response transaction carrying the mixed sample (131072 = 1.0,
// saturated to 22 bits). Voice state sits in one single-port-read,
// single-port-write memory of VOICES entries, walked one entry at a time.
// A note-on or note-off scans every voice entry, then updates the one it
// picks, if any. A tick walks every voice in turn; an attacking or releasing
// voice may pass through the serial 24-step divider of the attack and
// release ramps. One transaction is worked on at a time; req_stall stays
// high until it is done, and a finished sample waits in the response
// register while the next request is taken.
// Configuration writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
module polyphonic_sine_voice_synth #(
   parameter int VOICES          = psvs_pkg::VOICES_DEF,
   parameter int SINE_TABLE_BITS = psvs_pkg::SINE_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [psvs_pkg::ACTION_W-1:0]           req_action,
   input  logic [psvs_pkg::NOTE_W-1:0]             req_note,
   input  logic [psvs_pkg::VEL_W-1:0]              req_velocity,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [psvs_pkg::SAMPLE_W-1:0]    rsp_mixed_sample,
   input  logic                                    csr_wr_en,
   input  logic [psvs_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [psvs_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import psvs_pkg::*;

   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int QB     = SINE_TABLE_BITS - 2;
   localparam int QTR_N  = (1 << QB) + 1;
   localparam int ACC_W  = SINE_W + 1 + $clog2(VOICES);
   localparam int EXT_W  = (ACC_W > SAMPLE_W) ? ACC_W : SAMPLE_W;
   localparam int DCNT_W = $clog2(LEVEL_W);
   localparam int PROD_W = LEVEL_W + SINE_W;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_RD   = 11'b000_0000_0010,
      S_EVAL = 11'b000_0000_0100,
      S_PICK = 11'b000_0000_1000,
      S_MOD  = 11'b000_0001_0000,
      S_DIV  = 11'b000_0010_0000,
      S_ENVD = 11'b000_0100_0000,
      S_ATK  = 11'b000_1000_0000,
      S_MUL  = 11'b001_0000_0000,
      S_ACC  = 11'b010_0000_0000,
      S_OUT  = 11'b100_0000_0000
   } state_type;

   // constant tables
   logic [SINE_W-1:0]  sine_rom  [QTR_N];
   logic [PHASE_W-1:0] pitch_rom [NOTE_NUM];

   for (genvar g = 0; g < QTR_N; g++) begin : g_sine
      assign sine_rom[g] = sine_quarter(g, QB);
   end
   for (genvar g = 0; g < NOTE_NUM; g++) begin : g_pitch
      assign pitch_rom[g] = pitch_inc(g);
   end

   // configuration registers
   logic [COUNT_W-1:0] attack_cfg_ff;
   logic [COUNT_W-1:0] release_cfg_ff;
   logic [LEVEL_W-1:0] decay_cfg_ff;
   logic [LPV_W-1:0]   lpv_cfg_ff;

   // voice memory and its valid bits
   voice_type          voice_mem_ff [VOICES];
   logic [VOICES-1:0]  vld_ff;
   voice_type          rd_data_ff;
   logic               rd_vld_ff;
   logic [VIDX_W-1:0]  rd_addr;
   logic               mem_we;
   voice_type          mem_wdata;
   voice_type          rd_entry;

   // control and datapath registers
   state_type                  state_ff, state_in;
   logic [VIDX_W-1:0]          idx_ff, idx_in;
   logic [ACTION_W-1:0]        op_ff, op_in;
   logic [NOTE_W-1:0]          note_ff, note_in;
   logic [VEL_W-1:0]           vel_ff, vel_in;
   logic                       match_fnd_ff, match_fnd_in;
   logic [VIDX_W-1:0]          match_idx_ff, match_idx_in;
   logic                       free_fnd_ff, free_fnd_in;
   logic [VIDX_W-1:0]          free_idx_ff, free_idx_in;
   logic [VIDX_W-1:0]          min_idx_ff, min_idx_in;
   logic [LEVEL_W-1:0]         min_lvl_ff, min_lvl_in;
   voice_type                  work_ff, work_in;
   logic [LEVEL_W-1:0]         div_dvd_ff, div_dvd_in;
   logic [COUNT_W-1:0]         div_rem_ff, div_rem_in;
   logic [COUNT_W-1:0]         div_dsr_ff, div_dsr_in;
   logic [DCNT_W-1:0]          div_cnt_ff, div_cnt_in;
   logic                       div_neg_ff, div_neg_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic                       sgn_ff, sgn_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;

   always_comb begin
      logic                       last;
      logic [LEVEL_W:0]           diff;
      logic [COUNT_W:0]           rem_sh;
      logic                       ge;
      logic [LEVEL_W:0]           lvl_sum;
      logic [2*LEVEL_W-1:0]       decay_prod;
      logic [LEVEL_W+6:0]         lvl_x100;
      logic [LEVEL_W+6:0]         tgt_x99;
      logic [SINE_TABLE_BITS-1:0] ph_idx;
      logic [QB:0]                k;
      logic [SINE_W-1:0]          smag;
      logic [LEVEL_W:0]           tprod;
      logic [VIDX_W-1:0]          pick;
      logic signed [ACC_W-1:0]    mag_s;
      logic signed [EXT_W-1:0]    acc_ext;
      voice_type                  e;
      voice_type                  freed;

      state_in      = state_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      note_in       = note_ff;
      vel_in        = vel_ff;
      match_fnd_in  = match_fnd_ff;
      match_idx_in  = match_idx_ff;
      free_fnd_in   = free_fnd_ff;
      free_idx_in   = free_idx_ff;
      min_idx_in    = min_idx_ff;
      min_lvl_in    = min_lvl_ff;
      work_in       = work_ff;
      div_dvd_in    = div_dvd_ff;
      div_rem_in    = div_rem_ff;
      div_dsr_in    = div_dsr_ff;
      div_cnt_in    = div_cnt_ff;
      div_neg_in    = div_neg_ff;
      prod_in       = prod_ff;
      sgn_in        = sgn_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rd_addr       = idx_ff;
      mem_we        = 1'b0;
      mem_wdata     = work_ff;

      last       = (idx_ff == VIDX_W'(VOICES - 1));
      e          = rd_entry;
      diff       = {1'b0, e.target} - {1'b0, e.level};
      rem_sh     = {div_rem_ff, div_dvd_ff[LEVEL_W-1]};
      ge         = (rem_sh >= {1'b0, div_dsr_ff});
      lvl_sum    = div_neg_ff ? ({1'b0, work_ff.level} - {1'b0, div_dvd_ff})
                              : ({1'b0, work_ff.level} + {1'b0, div_dvd_ff});
      decay_prod = e.level * decay_cfg_ff;
      lvl_x100   = work_ff.level * 7'd100;
      tgt_x99    = work_ff.target * 7'd99;
      ph_idx     = work_ff.phase[PHASE_W-1 -: SINE_TABLE_BITS];
      k          = ph_idx[QB] ? ((QB+1)'(QTR_N - 1) - {1'b0, ph_idx[QB-1:0]})
                              : {1'b0, ph_idx[QB-1:0]};
      smag       = sine_rom[k];
      tprod      = (LEVEL_W+1)'(vel_ff * lpv_cfg_ff);
      pick       = match_fnd_ff ? match_idx_ff : (free_fnd_ff ? free_idx_ff : min_idx_ff);
      mag_s      = ACC_W'(prod_ff[PROD_W-1:LEVEL_W]);
      acc_ext    = EXT_W'(acc_ff);

      freed              = work_ff;
      freed.active       = 1'b0;
      freed.stage        = STG_FREED;
      freed.phase        = '0;
      freed.target       = '0;
      freed.level        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_action;
               note_in      = req_note;
               vel_in       = req_velocity;
               match_fnd_in = 1'b0;
               free_fnd_in  = 1'b0;
               acc_in       = '0;
               idx_in       = '0;
               if (req_action == ACT_NOTE_ON || req_action == ACT_NOTE_OFF ||
                   req_action == ACT_TICK) begin
                  state_in = S_RD;
               end
            end
         end

         S_RD: begin
            state_in = S_EVAL;
         end

         S_EVAL: begin
            if (op_ff == ACT_TICK) begin
               work_in = e;
               if (!e.active) begin
                  // silent voice: move on
                  if (last) begin
                     state_in = S_OUT;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_RD;
                  end
               end else begin
                  case (e.stage)
                     STG_ATTACK: begin
                        if (e.attack_left != '0) begin
                           div_neg_in = diff[LEVEL_W];
                           div_dvd_in = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
                           div_dsr_in = e.attack_left;
                           div_rem_in = '0;
                           div_cnt_in = '0;
                           state_in   = S_DIV;
                        end else begin
                           work_in.level = e.target;
                           work_in.stage = STG_SUSTAIN;
                           state_in      = S_MUL;
                        end
                     end
                     STG_SUSTAIN: begin
                        work_in.level = decay_prod[2*LEVEL_W-1:LEVEL_W];
                        state_in      = S_MUL;
                     end
                     STG_RELEASE: begin
                        if (e.release_left != '0) begin
                           div_neg_in = 1'b0;
                           div_dvd_in = e.target;
                           div_dsr_in = e.release_left;
                           div_rem_in = '0;
                           div_cnt_in = '0;
                           state_in   = S_DIV;
                        end else begin
                           // release count spent: free the voice
                           mem_we           = 1'b1;
                           mem_wdata        = e;
                           mem_wdata.active = 1'b0;
                           mem_wdata.stage  = STG_FREED;
                           mem_wdata.phase  = '0;
                           mem_wdata.target = '0;
                           mem_wdata.level  = '0;
                           if (last) begin
                              state_in = S_OUT;
                           end else begin
                              idx_in   = idx_ff + 1'b1;
                              state_in = S_RD;
                           end
                        end
                     end
                     default: begin
                        state_in = S_MUL;
                     end
                  endcase
               end
            end else begin
               if (op_ff == ACT_NOTE_ON) begin
                  if (e.active && e.note == note_ff && !match_fnd_ff) begin
                     match_fnd_in = 1'b1;
                     match_idx_in = idx_ff;
                  end
                  if (!e.active && !free_fnd_ff) begin
                     free_fnd_in = 1'b1;
                     free_idx_in = idx_ff;
                  end
                  if (idx_ff == '0 || e.level < min_lvl_ff) begin
                     min_idx_in = idx_ff;
                     min_lvl_in = e.level;
                  end
               end else begin
                  if (e.active && e.note == note_ff && !match_fnd_ff &&
                      (e.stage == STG_ATTACK || e.stage == STG_SUSTAIN)) begin
                     match_fnd_in = 1'b1;
                     match_idx_in = idx_ff;
                  end
               end
               if (last) begin
                  state_in = S_PICK;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end

         S_PICK: begin
            if (op_ff == ACT_NOTE_OFF && !match_fnd_ff) begin
               // no voice to release: drop
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               rd_addr  = pick;
               idx_in   = pick;
               state_in = S_MOD;
            end
         end

         S_MOD: begin
            mem_we    = 1'b1;
            mem_wdata = e;
            if (op_ff == ACT_NOTE_OFF) begin
               mem_wdata.stage        = STG_RELEASE;
               mem_wdata.release_left = release_cfg_ff;
            end else begin
               mem_wdata.stage       = STG_ATTACK;
               mem_wdata.target      = tprod[LEVEL_W] ? '1 : tprod[LEVEL_W-1:0];
               mem_wdata.attack_left = attack_cfg_ff;
               if (!match_fnd_ff) begin
                  mem_wdata.level  = '0;
                  mem_wdata.note   = note_ff;
                  mem_wdata.active = 1'b1;
                  mem_wdata.phase  = '0;
               end
            end
            idx_in   = '0;
            state_in = S_IDLE;
         end

         S_DIV: begin
            // one restoring quotient bit per cycle
            div_rem_in = ge ? COUNT_W'(rem_sh - {1'b0, div_dsr_ff}) : rem_sh[COUNT_W-1:0];
            div_dvd_in = {div_dvd_ff[LEVEL_W-2:0], ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DCNT_W'(LEVEL_W - 1)) begin
               state_in = S_ENVD;
            end
         end

         S_ENVD: begin
            if (work_ff.stage == STG_ATTACK) begin
               work_in.level       = lvl_sum[LEVEL_W-1:0];
               work_in.attack_left = work_ff.attack_left - 1'b1;
               state_in            = S_ATK;
            end else begin
               work_in.release_left = work_ff.release_left - 1'b1;
               if (work_ff.level > div_dvd_ff) begin
                  work_in.level = work_ff.level - div_dvd_ff;
                  state_in      = S_MUL;
               end else begin
                  mem_we                 = 1'b1;
                  mem_wdata              = freed;
                  mem_wdata.release_left = work_ff.release_left - 1'b1;
                  if (last) begin
                     state_in = S_OUT;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
            end
         end

         S_ATK: begin
            if (work_ff.attack_left == '0 || lvl_x100 >= tgt_x99) begin
               work_in.level = work_ff.target;
               work_in.stage = STG_SUSTAIN;
            end
            state_in = S_MUL;
         end

         S_MUL: begin
            prod_in  = work_ff.level * smag;
            sgn_in   = ph_idx[QB+1];
            state_in = S_ACC;
         end

         S_ACC: begin
            acc_in          = sgn_ff ? (acc_ff - mag_s) : (acc_ff + mag_s);
            mem_we          = 1'b1;
            mem_wdata       = work_ff;
            mem_wdata.phase = work_ff.phase + pitch_rom[work_ff.note];
            if (last) begin
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end

         S_OUT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (acc_ext > EXT_W'(MIX_MAX)) begin
                  rsp_sample_in = MIX_MAX;
               end else if (acc_ext < EXT_W'(MIX_MIN)) begin
                  rsp_sample_in = MIX_MIN;
               end else begin
                  rsp_sample_in = acc_ext[SAMPLE_W-1:0];
               end
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end

         default: begin
            idx_in   = '0;
            state_in = S_IDLE;
         end
      endcase
   end

   // voice memory: one read and one write port
   always_ff @(posedge clock) begin
      rd_data_ff <= voice_mem_ff[rd_addr];
      if (mem_we) begin
         voice_mem_ff[idx_ff] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (mem_we) begin
            vld_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_cfg_ff  <= ATTACK_RST;
         release_cfg_ff <= RELEASE_RST;
         decay_cfg_ff   <= DECAY_RST;
         lpv_cfg_ff     <= LPV_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ATTACK:  attack_cfg_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_RELEASE: release_cfg_ff <= csr_wdata[COUNT_W-1:0];
            CSR_DECAY:   decay_cfg_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_LPV:     lpv_cfg_ff     <= csr_wdata[LPV_W-1:0];
            default:     attack_cfg_ff  <= attack_cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      note_ff       <= note_in;
      vel_ff        <= vel_in;
      match_fnd_ff  <= match_fnd_in;
      match_idx_ff  <= match_idx_in;
      free_fnd_ff   <= free_fnd_in;
      free_idx_ff   <= free_idx_in;
      min_idx_ff    <= min_idx_in;
      min_lvl_ff    <= min_lvl_in;
      work_ff       <= work_in;
      div_dvd_ff    <= div_dvd_in;
      div_rem_ff    <= div_rem_in;
      div_dsr_ff    <= div_dsr_in;
      div_cnt_ff    <= div_cnt_in;
      div_neg_ff    <= div_neg_in;
      prod_ff       <= prod_in;
      sgn_ff        <= sgn_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
   end

`ifndef NO_ASSERTIONS
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_cnt_ff < DCNT_W'(LEVEL_W))
      else $error("divider ran past its last quotient bit");

   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> idx_ff == '0)
      else $error("voice index not rewound on return to idle");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside the output state");
`endif

endmodule
